### rtl/sidt_pkg.sv
package sidt_pkg;

  localparam int OP_W     = 2;
  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 9;
  localparam int CNT_W    = 64;
  localparam int LIMIT_W  = 9;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOMATCH = 2'd2;

  typedef struct packed {
    logic cmp_en;
    logic load_en;
    logic shift_en;
  } cell_ctl_t;

endpackage

### rtl/sidt_cell.sv
module sidt_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sidt_pkg::cell_ctl_t       ctl,
  input  logic [sidt_pkg::KEY_W-1:0]    cmp_key,
  input  logic [sidt_pkg::KEY_W-1:0]    wr_key,
  input  logic [sidt_pkg::HANDLE_W-1:0] wr_handle,
  input  logic [sidt_pkg::KEY_W-1:0]    nb_key,
  input  logic [sidt_pkg::HANDLE_W-1:0] nb_handle,
  input  logic                      nb_valid,
  output logic [sidt_pkg::KEY_W-1:0]    key,
  output logic [sidt_pkg::HANDLE_W-1:0] handle,
  output logic                      valid,
  output logic                      match
);
  import sidt_pkg::*;

  logic [KEY_W-1:0]    key_r;
  logic [HANDLE_W-1:0] handle_r;
  logic                valid_r;
  logic                match_r;

  always_ff @(posedge clk) begin
    if (ctl.load_en) begin
      key_r    <= wr_key;
      handle_r <= wr_handle;
    end else if (ctl.shift_en) begin
      key_r    <= nb_key;
      handle_r <= nb_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (ctl.load_en) begin
        valid_r <= 1'b1;
      end else if (ctl.shift_en) begin
        valid_r <= nb_valid;
      end
      if (ctl.cmp_en) begin
        match_r <= valid_r && (key_r == cmp_key);
      end
    end
  end

  assign key    = key_r;
  assign handle = handle_r;
  assign valid  = valid_r;
  assign match  = match_r;

endmodule

### rtl/sidt_select.sv
module sidt_select #(
  parameter int N = 256
) (
  input  logic [N-1:0]                          match,
  input  logic [N-1:0][sidt_pkg::HANDLE_W-1:0]  handles,
  output logic [N-1:0]                          shift_mask,
  output logic [N-1:0]                          hit,
  output logic                                  found,
  output logic [sidt_pkg::HANDLE_W-1:0]         hit_handle
);
  import sidt_pkg::*;

  localparam int LV = $clog2(N);

  logic [N-1:0] suffix;
  logic [N-1:0] above;

  always_comb begin
    suffix = match;
    for (int l = 0; l < LV; l++) begin
      for (int i = 0; i < N; i++) begin
        if (i + (1 << l) < N) begin
          suffix[i] = suffix[i] | suffix[i + (1 << l)];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (i + 1 < N) begin
        above[i] = suffix[i + 1];
      end else begin
        above[i] = 1'b0;
      end
    end
  end

  assign found      = suffix[0];
  assign hit        = match & ~above;
  assign shift_mask = {N{found}} & ~above;

  always_comb begin
    hit_handle = '0;
    for (int i = 0; i < N; i++) begin
      hit_handle = hit_handle | (hit[i] ? handles[i] : '0);
    end
  end

endmodule

### rtl/session_id_table_top.sv
// Session id table: a bounded table of (key, handle) entries held in a row of cells,
// oldest in cell 0, newest in the highest occupied cell.
// Input channel in_valid/in_stall carries one item: operation (insert, lookup, remove),
// session key and session handle. Output channel out_valid/out_stall returns one item
// per input: status, found handle, occupancy and the hit and miss totals.
// cfg_valid/cfg_ready writes the entry limit (0 or above CAPACITY means CAPACITY).
// Each item passes a compare state, in which every cell compares its key with the item
// key, then a select state that picks the newest match and updates the row (a remove
// shifts the newer cells down by one); the select state waits while an earlier result
// is stalled at the output. The result is registered; a new item is taken in the cycle
// the previous one finishes, and not before.
// While the receiver stalls, the finished result holds in the output register; one
// further item can be accepted and compared, then the table waits before updating.
// Reset empties the table, clears both totals and sets the limit to 256. No clearing
// pass is needed: the cells' valid bits clear at once.
module session_id_table_top #(
  parameter int CAPACITY = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [sidt_pkg::OP_W-1:0]        in_operation,
  input  logic [sidt_pkg::KEY_W-1:0]       in_session_key,
  input  logic [sidt_pkg::HANDLE_W-1:0]    in_session_handle,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sidt_pkg::STATUS_W-1:0]    out_status,
  output logic [sidt_pkg::HANDLE_W-1:0]    out_found_handle,
  output logic [sidt_pkg::OCC_W-1:0]       out_occupancy,
  output logic [sidt_pkg::CNT_W-1:0]       out_hit_total,
  output logic [sidt_pkg::CNT_W-1:0]       out_miss_total,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sidt_pkg::LIMIT_W-1:0]     cfg_data
);
  import sidt_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_SEL  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [OP_W-1:0]     op_r;
  logic [KEY_W-1:0]    key_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]    hits_r, hits_nxt;
  logic [CNT_W-1:0]    misses_r, misses_nxt;
  logic [LIMIT_W-1:0]  max_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r, status_nxt;
  logic [HANDLE_W-1:0] out_handle_r, found_nxt;
  logic [OCC_W-1:0]    out_occ_r;
  logic [CNT_W-1:0]    out_hits_r;
  logic [CNT_W-1:0]    out_misses_r;

  logic                accept;
  logic                finish;
  logic [LW-1:0]       limit;
  logic                full;
  logic                do_insert;
  logic                do_remove;

  logic [CAPACITY-1:0]               match;
  logic [CAPACITY-1:0]               shift_mask;
  logic [CAPACITY-1:0]               hit;
  logic                              found;
  logic [HANDLE_W-1:0]               hit_handle;
  logic [CAPACITY-1:0][KEY_W-1:0]    cell_key;
  logic [CAPACITY-1:0][HANDLE_W-1:0] cell_handle;
  logic [CAPACITY-1:0]               cell_valid;
  cell_ctl_t                         cell_ctl [CAPACITY];

  assign finish   = (state_r == S_SEL) && (!out_valid_r || !out_stall);
  assign in_stall = !((state_r == S_IDLE) || finish);
  assign accept   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (max_r == '0 || LW'(max_r) > LW'(CAPACITY)) begin
      limit = LW'(CAPACITY);
    end else begin
      limit = LW'(max_r);
    end
  end

  assign full      = LW'(count_r) >= limit;
  assign do_insert = finish && (op_r == OP_INSERT) && !full;
  assign do_remove = finish && (op_r == OP_REMOVE) && found;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0]    nb_key;
    logic [HANDLE_W-1:0] nb_handle;
    logic                nb_valid;

    if (i + 1 < CAPACITY) begin : g_nb
      assign nb_key    = cell_key[i+1];
      assign nb_handle = cell_handle[i+1];
      assign nb_valid  = cell_valid[i+1];
    end else begin : g_top
      assign nb_key    = '0;
      assign nb_handle = '0;
      assign nb_valid  = 1'b0;
    end

    assign cell_ctl[i].cmp_en   = (state_r == S_CMP);
    assign cell_ctl[i].load_en  = do_insert && (count_r == CW'(i));
    assign cell_ctl[i].shift_en = do_remove && shift_mask[i];

    sidt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl[i]),
      .cmp_key   (key_r),
      .wr_key    (key_r),
      .wr_handle (handle_r),
      .nb_key    (nb_key),
      .nb_handle (nb_handle),
      .nb_valid  (nb_valid),
      .key       (cell_key[i]),
      .handle    (cell_handle[i]),
      .valid     (cell_valid[i]),
      .match     (match[i])
    );
  end

  sidt_select #(
    .N (CAPACITY)
  ) u_select (
    .match      (match),
    .handles    (cell_handle),
    .shift_mask (shift_mask),
    .hit        (hit),
    .found      (found),
    .hit_handle (hit_handle)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = S_SEL;
      end
      S_SEL: begin
        if (accept) begin
          state_nxt = S_CMP;
        end else if (finish) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    count_nxt  = count_r;
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    status_nxt = STAT_OK;
    found_nxt  = '0;
    unique case (op_r)
      OP_INSERT: begin
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      OP_LOOKUP: begin
        if (found) begin
          found_nxt = hit_handle;
          hits_nxt  = hits_r + CNT_W'(1);
        end else begin
          status_nxt = STAT_NOMATCH;
          misses_nxt = misses_r + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (found) begin
          found_nxt = hit_handle;
          count_nxt = count_r - CW'(1);
        end else begin
          status_nxt = STAT_NOMATCH;
        end
      end
      default: begin
        status_nxt = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_operation;
      key_r    <= in_session_key;
      handle_r <= in_session_handle;
    end
    if (finish) begin
      out_status_r <= status_nxt;
      out_handle_r <= found_nxt;
      out_occ_r    <= OCC_W'(count_nxt);
      out_hits_r   <= hits_nxt;
      out_misses_r <= misses_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      max_r       <= LIMIT_W'(256);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        count_r  <= count_nxt;
        hits_r   <= hits_nxt;
        misses_r <= misses_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        max_r <= cfg_data;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found_handle = out_handle_r;
  assign out_occupancy    = out_occ_r;
  assign out_hit_total    = out_hits_r;
  assign out_miss_total   = out_misses_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    LW'(count_r) <= LW'(CAPACITY))
    else $error("occupancy above capacity");

  a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_valid_r)
    else $error("finished item not presented");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEL) |-> $onehot0(hit))
    else $error("more than one newest match");

  a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
    !finish |=> $stable(count_r))
    else $error("occupancy changed outside an update");

endmodule

### test/session_id_table_top_tb.sv
module session_id_table_top_tb;
  import sidt_pkg::*;

  localparam int TBL_CAP     = 256;
  localparam int IDLE_PCT    = 37;
  localparam int HOLD_CYCLES = 64;
  localparam int WATCHDOG    = 2000;
  localparam int TAIL_CYCLES = 10;
  localparam int N_DIR       = 29;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] found;
    logic [OCC_W-1:0]    occ;
    logic [CNT_W-1:0]    hits;
    logic [CNT_W-1:0]    misses;
  } sess_result_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } sess_entry_t;

  typedef struct packed {
    logic                is_cfg;
    logic [LIMIT_W-1:0]  limit;
    logic [OP_W-1:0]     op;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic                typed;
    sess_result_t        want;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [OP_W-1:0]     in_operation;
  logic [KEY_W-1:0]    in_session_key;
  logic [HANDLE_W-1:0] in_session_handle;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [HANDLE_W-1:0] out_found_handle;
  logic [OCC_W-1:0]    out_occupancy;
  logic [CNT_W-1:0]    out_hit_total;
  logic [CNT_W-1:0]    out_miss_total;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [LIMIT_W-1:0]  cfg_data;

  sess_entry_t  session_rows[$];
  sess_result_t pending_results[$];
  logic [LIMIT_W-1:0] limit_reg;
  logic [CNT_W-1:0]   hit_cnt;
  logic [CNT_W-1:0]   miss_cnt;
  logic [KEY_W-1:0]   key_pool[8];

  bit hold_req;
  bit no_idle;
  int errors;
  int n_items;
  int n_dir_items;
  int n_checked;
  int n_full;
  int peak_occ;
  int idle_cycles;

  dir_row_t dir_rows [N_DIR] = '{
    '{1'b1, 9'd1,   OP_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{1'b0, 9'd0,   OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{STAT_NOMATCH, 32'h0, 9'd0, 64'd0, 64'd1}},
    '{1'b0, 9'd0,   OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{STAT_NOMATCH, 32'h0, 9'd0, 64'd0, 64'd1}},
    '{1'b0, 9'd0,   OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
      '{STAT_OK, 32'h0, 9'd1, 64'd0, 64'd1}},
    '{1'b0, 9'd0,   OP_INSERT, 32'h0000_0001, 32'h0000_0001, 1'b1,
      '{STAT_FULL, 32'h0, 9'd1, 64'd0, 64'd1}},
    '{1'b0, 9'd0,   OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{STAT_OK, 32'hFFFF_FFFF, 9'd1, 64'd1, 64'd1}},
    '{1'b0, 9'd0,   OP_UNUSED, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
      '{STAT_OK, 32'h0, 9'd1, 64'd1, 64'd1}},
    '{1'b1, 9'd3,   OP_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{1'b0, 9'd0,   OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
      '{STAT_OK, 32'h0, 9'd2, 64'd1, 64'd1}},
    '{1'b0, 9'd0,   OP_INSERT, 32'h0000_0000, 32'h1234_5678, 1'b1,
      '{STAT_OK, 32'h0, 9'd3, 64'd1, 64'd1}},
    '{1'b0, 9'd0,   OP_INSERT, 32'h0000_0002, 32'h0000_0002, 1'b1,
      '{STAT_FULL, 32'h0, 9'd3, 64'd1, 64'd1}},
    '{1'b0, 9'd0,   OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
      '{STAT_OK, 32'h1234_5678, 9'd3, 64'd2, 64'd1}},
    '{1'b0, 9'd0,   OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{STAT_OK, 32'h0, 9'd3, 64'd3, 64'd1}},
    '{1'b1, 9'd2,   OP_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{1'b0, 9'd0,   OP_INSERT, 32'h0000_0003, 32'h0000_0003, 1'b1,
      '{STAT_FULL, 32'h0, 9'd3, 64'd3, 64'd1}},
    '{1'b0, 9'd0,   OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{STAT_OK, 32'h1234_5678, 9'd2, 64'd3, 64'd1}},
    '{1'b0, 9'd0,   OP_INSERT, 32'h0000_0004, 32'h0000_0004, 1'b1,
      '{STAT_FULL, 32'h0, 9'd2, 64'd3, 64'd1}},
    '{1'b0, 9'd0,   OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{STAT_OK, 32'hFFFF_FFFF, 9'd1, 64'd3, 64'd1}},
    '{1'b0, 9'd0,   OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{STAT_NOMATCH, 32'h0, 9'd1, 64'd3, 64'd2}},
    '{1'b0, 9'd0,   OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{STAT_NOMATCH, 32'h0, 9'd1, 64'd3, 64'd2}},
    '{1'b0, 9'd0,   OP_INSERT, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1,
      '{STAT_OK, 32'h0, 9'd2, 64'd3, 64'd2}},
    '{1'b1, 9'd0,   OP_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{1'b0, 9'd0,   OP_INSERT, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b1,
      '{STAT_OK, 32'h0, 9'd3, 64'd3, 64'd2}},
    '{1'b1, 9'd511, OP_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{1'b0, 9'd0,   OP_INSERT, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 1'b1,
      '{STAT_OK, 32'h0, 9'd4, 64'd3, 64'd2}},
    '{1'b0, 9'd0,   OP_REMOVE, 32'hA5A5_A5A5, 32'h0000_0000, 1'b0, '0},
    '{1'b0, 9'd0,   OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
    '{1'b0, 9'd0,   OP_UNUSED, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
    '{1'b0, 9'd0,   OP_LOOKUP, 32'h5A5A_5A5A, 32'hFFFF_FFFF, 1'b0, '0}
  };

  session_id_table_top #(
    .CAPACITY(TBL_CAP)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_session_key   (in_session_key),
    .in_session_handle(in_session_handle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_found_handle (out_found_handle),
    .out_occupancy    (out_occupancy),
    .out_hit_total    (out_hit_total),
    .out_miss_total   (out_miss_total),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic sess_result_t session_table_apply(input logic [OP_W-1:0] op,
                                                       input logic [KEY_W-1:0] key,
                                                       input logic [HANDLE_W-1:0] handle);
    sess_result_t r;
    sess_entry_t  e;
    int           slot;
    int           lim;
    r = '0;
    r.status = STAT_OK;
    slot = -1;
    lim = int'(limit_reg);
    if (lim == 0 || lim > TBL_CAP) lim = TBL_CAP;
    for (int i = session_rows.size() - 1; i >= 0 && slot < 0; i--) begin
      if (session_rows[i].key == key) slot = i;
    end
    case (op)
      OP_INSERT: begin
        if (session_rows.size() >= lim) begin
          r.status = STAT_FULL;
        end else begin
          e.key = key;
          e.handle = handle;
          session_rows.push_back(e);
        end
      end
      OP_LOOKUP: begin
        if (slot >= 0) begin
          r.found = session_rows[slot].handle;
          hit_cnt++;
        end else begin
          r.status = STAT_NOMATCH;
          miss_cnt++;
        end
      end
      OP_REMOVE: begin
        if (slot >= 0) begin
          r.found = session_rows[slot].handle;
          session_rows.delete(slot);
        end else begin
          r.status = STAT_NOMATCH;
        end
      end
      default: ;
    endcase
    if (session_rows.size() > peak_occ) peak_occ = session_rows.size();
    r.occ = OCC_W'(session_rows.size());
    r.hits = hit_cnt;
    r.misses = miss_cnt;
    return r;
  endfunction

  // mostly keys already held, so lookups and removes hit and duplicates build up
  function automatic logic [KEY_W-1:0] pick_key();
    if (session_rows.size() != 0 && $urandom_range(0, 99) < 70)
      return session_rows[$urandom_range(0, session_rows.size() - 1)].key;
    if ($urandom_range(0, 1) == 1) return key_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [HANDLE_W-1:0] handle, input bit typed,
                           input sess_result_t want);
    sess_result_t got;
    while (!no_idle && !hold_req && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_operation      <= op;
    in_session_key    <= key;
    in_session_handle <= handle;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = session_table_apply(op, key, handle);
    pending_results.push_back(typed ? want : got);
    n_items++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] lim);
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_reg = lim;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int n_ops, input int w_ins,
                           input int w_look, input int w_rem, input bit fill);
    int               done;
    int               at_cap;
    int               r;
    logic [OP_W-1:0]  op;
    drain();
    write_limit(lim);
    done = 0;
    at_cap = 0;
    while (fill ? (at_cap < 20 && done < 600) : (done < n_ops)) begin
      r = $urandom_range(0, 99);
      if (r < w_ins) op = OP_INSERT;
      else if (r < w_ins + w_look) op = OP_LOOKUP;
      else if (r < w_ins + w_look + w_rem) op = OP_REMOVE;
      else op = OP_UNUSED;
      if (fill && done == 40) hold_req = 1'b1;
      send_item(op, pick_key(), $urandom(), 1'b0, '0);
      done++;
      if (fill && session_rows.size() == TBL_CAP) at_cap++;
    end
  endtask

  task automatic check_field(input string what, input logic [CNT_W-1:0] want_v,
                             input logic [CNT_W-1:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    sess_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected item: expected none, actual status 0x%0h handle 0x%0h",
                 $time, out_status, out_found_handle);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (want.status == STAT_FULL) n_full++;
        check_field("status", CNT_W'(want.status), CNT_W'(out_status));
        check_field("found_handle", CNT_W'(want.found), CNT_W'(out_found_handle));
        check_field("occupancy", CNT_W'(want.occ), CNT_W'(out_occupancy));
        check_field("hit_total", want.hits, out_hit_total);
        check_field("miss_total", want.misses, out_miss_total);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == WATCHDOG) begin
      $display("%0t no handshake for %0d cycles", $time, WATCHDOG);
      $display("tb: failure");
      $finish;
    end
  end

  // hold off the output for a long stretch on request, otherwise stall at random unless no_idle is set
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (no_idle) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_operation      = OP_INSERT;
    in_session_key    = '0;
    in_session_handle = '0;
    cfg_valid         = 1'b0;
    cfg_data          = '0;
    limit_reg         = 9'd256;
    hit_cnt           = '0;
    miss_cnt          = '0;
    hold_req          = 1'b0;
    no_idle           = 1'b0;
    errors            = 0;
    n_items           = 0;
    n_checked         = 0;
    n_full            = 0;
    peak_occ          = 0;
    idle_cycles       = 0;
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].is_cfg) begin
        drain();
        write_limit(dir_rows[i].limit);
      end else begin
        send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].handle,
                  dir_rows[i].typed, dir_rows[i].want);
      end
    end
    n_dir_items = n_items;

    run_phase(LIMIT_W'($urandom_range(4, 16)), 60, 45, 25, 25, 1'b0);
    run_phase(9'd0, 0, 88, 7, 3, 1'b1);
    run_phase(9'd511, 60, 15, 35, 45, 1'b0);
    no_idle = 1'b1;
    run_phase(LIMIT_W'($urandom_range(1, 255)), 60, 40, 30, 27, 1'b0);
    no_idle = 1'b0;
    run_phase(9'd256, 40, 35, 30, 30, 1'b0);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t %0d expected items never arrived", $time, pending_results.size());
    end

    $display("tb: %0d items sent (%0d directed), %0d results checked, %0d table-full",
             n_items, n_dir_items, n_checked, n_full);
    $display("tb: peak occupancy %0d, limits 1/2/3/0/511/256 and random, output held %0d cycles",
             peak_occ, HOLD_CYCLES);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### session_id_table_top.f
rtl/sidt_pkg.sv
rtl/sidt_cell.sv
rtl/sidt_select.sv
rtl/session_id_table_top.sv
test/session_id_table_top_tb.sv
